// ----- src/bfiq_pkg.sv -----
package bfiq_pkg;

  localparam int FILTER_BITS = 1024;
  localparam int MAX_HASHES  = 4;
  localparam int COEF_REGS   = 4;
  localparam int IDX_W       = $clog2(FILTER_BITS);
  localparam int HSEL_W      = 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_USED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3      = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_SUM,
    ST_DIV1,
    ST_DIV2,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Request to and answer from the iterative remainder unit.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

// ----- src/bloom_filter_insert_query_core.sv -----
// Each accepted item runs its hashes one after another; each hash spends two 64-step
// remainder passes in the shared bit-serial divider.
// The core works on one item at a time and accepts a new one only in its idle state.
// A result that waits holds the next item in its final state until the result is taken.
// Reset (rst_n, synchronous, active low) restores the register defaults and then
// runs a clearing pass over all 1024 bits of the store before accepting items.
module bloom_filter_insert_query_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_op_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IW = bfiq_pkg::IDX_W;
  localparam int HW = bfiq_pkg::HSEL_W + 1;

  bfiq_pkg::state_t state_r, state_nxt;

  logic [2:0]  num_hashes_r;
  logic [30:0] prime_r;
  logic [10:0] bits_used_r;
  logic [63:0] coef_r [bfiq_pkg::COEF_REGS];

  logic        kind_r;
  logic [63:0] key_r;
  logic [63:0] prod_r;
  logic [63:0] val_r, val_nxt;
  logic [bfiq_pkg::HSEL_W:0] h_r, h_nxt;
  logic [2:0]  n_use;
  logic        hit_r, hit_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] clr_r;
  logic        out_valid_r, out_hit_r, out_kind_r;
  logic        out_load;

  logic [10:0] m_eff;
  logic [31:0] coef_a;
  logic [31:0] coef_b;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  bfiq_pkg::div_req_t dreq;
  bfiq_pkg::div_rsp_t drsp;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;

  bfiq_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  bfiq_ram #(.WIDTH(1), .DEPTH(bfiq_pkg::FILTER_BITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Effective counts after clamping.
  always_comb begin
    n_use = (num_hashes_r > 3'(bfiq_pkg::MAX_HASHES)) ? 3'(bfiq_pkg::MAX_HASHES)
                                                      : num_hashes_r;
    m_eff = (bits_used_r > 11'(bfiq_pkg::FILTER_BITS)) ? 11'(bfiq_pkg::FILTER_BITS)
                                                       : bits_used_r;
    coef_a = coef_r[h_r[bfiq_pkg::HSEL_W-1:0]][63:32];
    coef_b = coef_r[h_r[bfiq_pkg::HSEL_W-1:0]][31:0];
  end

  // One 32 x 32 multiplier: low key half in the multiply state, high half in the sum state.
  always_comb begin
    mul_b = (state_r == bfiq_pkg::ST_SUM) ? key_r[63:32] : key_r[31:0];
    mul_p = {32'd0, coef_a} * {32'd0, mul_b};
  end

  assign out_load    = (state_r == bfiq_pkg::ST_DONE) && (!out_valid_r || out_ready);
  assign in_ready    = (state_r == bfiq_pkg::ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_op_done = out_kind_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfiq_pkg::ST_CLEAR: begin
        if (clr_r == IW'(bfiq_pkg::FILTER_BITS - 1)) state_nxt = bfiq_pkg::ST_IDLE;
      end
      bfiq_pkg::ST_IDLE: begin
        if (in_valid && in_ready) state_nxt = bfiq_pkg::ST_MUL;
      end
      bfiq_pkg::ST_MUL: begin
        if (h_r >= {1'b0, n_use[1:0]} && !(n_use == 3'd4 && h_r < 3'd4))
          state_nxt = bfiq_pkg::ST_DONE;
        else
          state_nxt = bfiq_pkg::ST_SUM;
      end
      bfiq_pkg::ST_SUM:  state_nxt = bfiq_pkg::ST_DIV1;
      bfiq_pkg::ST_DIV1: if (drsp.done) state_nxt = bfiq_pkg::ST_DIV2;
      bfiq_pkg::ST_DIV2: if (drsp.done) state_nxt = bfiq_pkg::ST_READ;
      bfiq_pkg::ST_READ: state_nxt = bfiq_pkg::ST_CHECK;
      bfiq_pkg::ST_CHECK: state_nxt = bfiq_pkg::ST_MUL;
      bfiq_pkg::ST_DONE: if (out_load) state_nxt = bfiq_pkg::ST_IDLE;
      default: state_nxt = bfiq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and control outputs.
  always_comb begin
    dreq          = '0;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    h_nxt         = h_r;
    hit_nxt       = hit_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = 1'b1;
    case (state_r)
      bfiq_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
      end
      bfiq_pkg::ST_IDLE: begin
        h_nxt   = '0;
        hit_nxt = in_kind;
      end
      bfiq_pkg::ST_SUM: begin
        val_nxt = prod_r + {mul_p[31:0], 32'd0} + {32'd0, coef_b};
      end
      bfiq_pkg::ST_DIV1: begin
        if (prime_r == 31'd0) begin
          dreq.start    = !drsp.busy && !drsp.done;
          dreq.dividend = val_r;
          dreq.divisor  = {20'd0, m_eff};
        end else begin
          dreq.start    = !drsp.busy && !drsp.done;
          dreq.dividend = val_r;
          dreq.divisor  = prime_r;
        end
        if (drsp.done) begin
          val_nxt = drsp.rem;
        end
      end
      bfiq_pkg::ST_DIV2: begin
        dreq.start    = !drsp.busy && !drsp.done;
        dreq.dividend = val_r;
        dreq.divisor  = {20'd0, m_eff};
        if (drsp.done) begin
          idx_nxt = (m_eff == 11'd0) ? '0 : drsp.rem[IW-1:0];
        end
      end
      bfiq_pkg::ST_CHECK: begin
        h_nxt = h_r + HW'(1);
        if (kind_r) begin
          if (!ram_rdata) hit_nxt = 1'b0;
        end else begin
          ram_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfiq_pkg::ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      num_hashes_r <= 3'd4;
      prime_r      <= 31'd2147483647;
      bits_used_r  <= 11'd1024;
      coef_r[0]    <= 64'd4294967297;
      coef_r[1]    <= 64'd12884901891;
      coef_r[2]    <= 64'd21474836485;
      coef_r[3]    <= 64'd30064771079;
    end else begin
      state_r <= state_nxt;
      if (state_r == bfiq_pkg::ST_CLEAR) clr_r <= clr_r + IW'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Configuration transactions.
      if (cfg_valid) begin
        case (cfg_index)
          bfiq_pkg::REG_NUM_HASHES: num_hashes_r <= cfg_data[2:0];
          bfiq_pkg::REG_PRIME:      prime_r      <= cfg_data[30:0];
          bfiq_pkg::REG_BITS_USED:  bits_used_r  <= cfg_data[10:0];
          bfiq_pkg::REG_COEF0:      coef_r[0]    <= cfg_data;
          bfiq_pkg::REG_COEF1:      coef_r[1]    <= cfg_data;
          bfiq_pkg::REG_COEF2:      coef_r[2]    <= cfg_data;
          bfiq_pkg::REG_COEF3:      coef_r[3]    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    if (state_r == bfiq_pkg::ST_IDLE && in_valid && in_ready) begin
      kind_r <= in_kind;
      key_r  <= in_key;
    end
    if (out_load) begin
      out_hit_r  <= hit_r;
      out_kind_r <= kind_r;
    end
    // Low partial product, taken in the multiply state.
    prod_r <= mul_p;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    h_r    <= h_nxt;
    hit_r  <= hit_nxt;
  end

endmodule

// ----- src/bfiq_ram.sv -----
module bfiq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bfiq_rem.sv -----
module bfiq_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  bfiq_pkg::div_req_t req,
  output bfiq_pkg::div_rsp_t rsp
);

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [30:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted  = {rem_r, quo_r[63]};
    diff     = shifted - {34'd0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = 64'd0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], 1'b0};
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
      end else begin
        rem_nxt = shifted[63:0];
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 115;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct {
    row_kind_t   row;
    logic        kind;
    logic [63:0] val;
    logic [2:0]  idx;
    bit          typed;
    logic        typed_hit;
  } stim_row_t;

  typedef struct {
    logic hit;
    logic op_done;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [63:0] in_key;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic        out_op_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // Predictor state.
  bit          filter_model [bfiq_pkg::FILTER_BITS];
  logic [2:0]  hash_count;
  logic [30:0] prime_mod;
  logic [10:0] bits_in_use;
  logic [63:0] coef_model [bfiq_pkg::COEF_REGS];

  answer_t     answer_q[$];
  logic [63:0] inserted_keys[$];
  int          errors;
  int          cycles;
  int          snd_idle;
  int          rcv_idle;

  bloom_filter_insert_query_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_op_done(out_op_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bit position selected by hash h for a key.
  function automatic int bit_slot(int h, logic [63:0] key);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] v;
    int          m;
    a = {32'd0, coef_model[h][63:32]};
    b = {32'd0, coef_model[h][31:0]};
    v = a * key + b;
    if (prime_mod != 0) v = v % {33'd0, prime_mod};
    m = bits_in_use;
    if (m > bfiq_pkg::FILTER_BITS) m = bfiq_pkg::FILTER_BITS;
    if (m == 0) return 0;
    return int'(v % m);
  endfunction

  // Update the filter model for one item and return the expected hit.
  function automatic logic filter_lookup(logic kind, logic [63:0] key);
    int   n;
    logic hit;
    n = hash_count;
    if (n > bfiq_pkg::MAX_HASHES) n = bfiq_pkg::MAX_HASHES;
    if (n > bfiq_pkg::COEF_REGS) n = bfiq_pkg::COEF_REGS;
    hit = (kind == KIND_QUERY);
    for (int h = 0; h < n; h++) begin
      if (kind == KIND_INSERT) filter_model[bit_slot(h, key)] = 1'b1;
      else if (!filter_model[bit_slot(h, key)]) hit = 1'b0;
    end
    return hit;
  endfunction

  // Send one transaction on the input channel; the caller stands at a falling edge.
  task automatic send_item(logic kind, logic [63:0] key, bit typed, logic typed_hit);
    answer_t a;
    logic    hit;
    while ($urandom_range(99, 0) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind  = kind;
    in_key   = key;
    do @(posedge clk); while (!in_ready);
    hit = filter_lookup(kind, key);
    a.hit     = typed ? typed_hit : hit;
    a.op_done = kind;
    answer_q.push_back(a);
    if (kind == KIND_INSERT) inserted_keys.push_back(key);
    @(negedge clk);
  endtask

  // Wait until every expected result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bfiq_pkg::REG_NUM_HASHES: hash_count  = data[2:0];
      bfiq_pkg::REG_PRIME:      prime_mod   = data[30:0];
      bfiq_pkg::REG_BITS_USED:  bits_in_use = data[10:0];
      bfiq_pkg::REG_COEF0, bfiq_pkg::REG_COEF1, bfiq_pkg::REG_COEF2,
      bfiq_pkg::REG_COEF3: coef_model[idx - bfiq_pkg::REG_COEF0] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic stim_row_t item_row(logic kind, logic [63:0] key, bit typed,
                                         logic hit);
    stim_row_t r;
    r.row = ROW_ITEM; r.kind = kind; r.val = key; r.idx = '0;
    r.typed = typed; r.typed_hit = hit;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [63:0] data);
    stim_row_t r;
    r.row = ROW_CFG; r.kind = 1'b0; r.val = data; r.idx = idx;
    r.typed = 1'b0; r.typed_hit = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a random value for a register, with the extremes often.
  function automatic logic [63:0] pick_reg(logic [2:0] idx);
    case (idx)
      bfiq_pkg::REG_NUM_HASHES: return {$urandom(), 29'd0, 3'($urandom_range(7, 0))};
      bfiq_pkg::REG_PRIME: begin
        case ($urandom_range(5, 0))
          0: return 64'd0;
          1: return 64'd2;
          2: return 64'd2147483647;
          3: return 64'($urandom_range(2000, 3));
          default: return rand64();
        endcase
      end
      bfiq_pkg::REG_BITS_USED: begin
        case ($urandom_range(6, 0))
          0: return 64'd0;
          1: return 64'd1;
          2: return 64'd1024;
          3: return 64'd2047;
          4: return 64'($urandom_range(64, 2));
          default: return rand64();
        endcase
      end
      default: begin
        case ($urandom_range(5, 0))
          0: return 64'd0;
          1: return '1;
          default: return rand64();
        endcase
      end
    endcase
  endfunction

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b op_done=%0b", $time, out_hit,
                 out_op_done);
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (out_hit !== a.hit) begin
          $display("%0t: hit mismatch expected %0b actual %0b", $time, a.hit, out_hit);
          errors++;
        end
        if (out_op_done !== a.op_done) begin
          $display("%0t: op_done mismatch expected %0b actual %0b", $time, a.op_done,
                   out_op_done);
          errors++;
        end
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= rcv_idle);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bloom_filter_insert_query_core");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows[$];
    logic [63:0] key;
    logic        kind;
    clk = 1'b0; rst_n = 1'b0;
    in_valid = 1'b0; in_kind = 1'b0; in_key = '0;
    out_ready = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; cycles = 0;
    snd_idle = 34; rcv_idle = 61;
    foreach (filter_model[i]) filter_model[i] = 1'b0;
    hash_count = 3'd4; prime_mod = 31'd2147483647; bits_in_use = 11'd1024;
    coef_model[0] = 64'd4294967297; coef_model[1] = 64'd12884901891;
    coef_model[2] = 64'd21474836485; coef_model[3] = 64'd30064771079;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: reset defaults, key extremes, then the special settings.
    rows.push_back(item_row(KIND_QUERY, 64'd0, 1, 1'b0));
    rows.push_back(item_row(KIND_QUERY, '1, 1, 1'b0));
    rows.push_back(item_row(KIND_INSERT, 64'd0, 1, 1'b0));
    rows.push_back(item_row(KIND_INSERT, '1, 1, 1'b0));
    rows.push_back(item_row(KIND_QUERY, 64'd0, 0, 1'b0));
    rows.push_back(item_row(KIND_QUERY, '1, 0, 1'b0));
    rows.push_back(item_row(KIND_QUERY, 64'h8000_0000_0000_0000, 0, 1'b0));
    // No hash in use: a query always hits.
    rows.push_back(cfg_row(bfiq_pkg::REG_NUM_HASHES, 64'd0));
    rows.push_back(item_row(KIND_INSERT, 64'h1234_5678_9abc_def0, 1, 1'b0));
    rows.push_back(item_row(KIND_QUERY, 64'h0fed_cba9_8765_4321, 1, 1'b1));
    // Too many hashes is clamped to four.
    rows.push_back(cfg_row(bfiq_pkg::REG_NUM_HASHES, 64'd7));
    rows.push_back(item_row(KIND_INSERT, 64'd77, 0, 1'b0));
    rows.push_back(item_row(KIND_QUERY, 64'd77, 0, 1'b0));
    // Prime of zero skips the first modulo.
    rows.push_back(cfg_row(bfiq_pkg::REG_PRIME, 64'd0));
    rows.push_back(cfg_row(bfiq_pkg::REG_COEF0, '1));
    rows.push_back(item_row(KIND_INSERT, '1, 0, 1'b0));
    rows.push_back(item_row(KIND_QUERY, 64'hffff_ffff_0000_0000, 0, 1'b0));
    // Zero bits in use sends every index to bit 0.
    rows.push_back(cfg_row(bfiq_pkg::REG_BITS_USED, 64'd0));
    rows.push_back(item_row(KIND_QUERY, 64'd5, 0, 1'b0));
    // Bits in use above the store size is clamped.
    rows.push_back(cfg_row(bfiq_pkg::REG_BITS_USED, 64'd2047));
    rows.push_back(cfg_row(bfiq_pkg::REG_PRIME, 64'd2));
    rows.push_back(item_row(KIND_QUERY, 64'd9, 0, 1'b0));
    // Index beyond the register list is ignored.
    rows.push_back(cfg_row(3'd7, '1));
    rows.push_back(cfg_row(bfiq_pkg::REG_COEF1, 64'd0));
    rows.push_back(cfg_row(bfiq_pkg::REG_COEF2, '1));
    rows.push_back(cfg_row(bfiq_pkg::REG_COEF3, 64'h0000_0001_ffff_ffff));
    rows.push_back(item_row(KIND_INSERT, 64'd3, 0, 1'b0));
    rows.push_back(item_row(KIND_QUERY, 64'd3, 0, 1'b0));

    @(negedge clk);
    foreach (rows[i]) begin
      if (rows[i].row == ROW_CFG) write_reg(rows[i].idx, rows[i].val);
      else send_item(rows[i].kind, rows[i].val, rows[i].typed, rows[i].typed_hit);
    end

    // Random phases, each with a new setting of every register.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p * 3 / RAND_PHASES)
        0: begin snd_idle = 34; rcv_idle = 61; end
        1: begin snd_idle = 61; rcv_idle = 34; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      for (int r = 0; r <= bfiq_pkg::REG_COEF3; r++) write_reg(3'(r), pick_reg(3'(r)));
      if (p == 0) write_reg(bfiq_pkg::REG_BITS_USED, 64'd1024);
      if (p == RAND_PHASES - 1) write_reg(bfiq_pkg::REG_BITS_USED, 64'd1);
      inserted_keys.delete();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Half inserts of fresh keys, half queries: mostly of keys already inserted, some noise.
        if ($urandom_range(1, 0) == 0 || inserted_keys.size() == 0) begin
          kind = KIND_INSERT;
          key  = rand64();
        end else begin
          kind = KIND_QUERY;
          if ($urandom_range(3, 0) != 0)
            key = inserted_keys[$urandom_range(inserted_keys.size() - 1, 0)];
          else
            key = rand64();
        end
        send_item(kind, key, 0, 1'b0);
      end
    end

    drain();
    repeat (600) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("PASS bloom_filter_insert_query_core");
    end else begin
      $display("FAIL bloom_filter_insert_query_core");
    end
    $finish;
  end

endmodule
